FILE: rtl/dsv_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsv_pkg: shared types and constants of the date string validator
// field codes, character codes, parser state and result records
// ----------------------------------------------------------------------------
package dsv_pkg;

  // character codes
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  // calendar constants
  localparam logic [13:0] YEAR_BASE    = 14'd2000;
  localparam logic [13:0] YEAR_SMALL   = 14'd100;
  localparam logic [6:0]  MON_FEB      = 7'd2;
  localparam logic [6:0]  MON_MAX      = 7'd12;
  localparam logic [4:0]  DAYS_LEAPFEB = 5'd29;

  // digit limits and saturation
  localparam logic [2:0] DIG_LIM_DM  = 3'd2;
  localparam logic [2:0] DIG_LIM_Y   = 3'd4;
  localparam logic [2:0] DIG_SAT     = 3'd7;
  localparam logic [1:0] SLASH_SAT   = 2'd3;
  localparam logic [1:0] SLASH_NEED  = 2'd2;

  typedef enum logic [1:0] {
    FLD_DAY   = 2'd0,
    FLD_MONTH = 2'd1,
    FLD_YEAR  = 2'd2
  } field_t;

  typedef logic [6:0]  day_t;
  typedef logic [6:0]  month_t;
  typedef logic [13:0] year_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } item_t;

  typedef struct packed {
    field_t          field;
    logic [1:0]      slash_cnt;
    logic [2:0]      dig_cnt;
    day_t            day_acc;
    month_t          month_acc;
    year_t           year_acc;
    logic [3:0][3:0] year_dig;   // last four year digits, [0] is units
    logic            bad;
  } pstate_t;

  typedef struct packed {
    logic   valid_res;
    day_t   day;
    month_t month;
    year_t  year;
  } res_t;

  // days in a common year, month assumed 1..12
  function automatic logic [4:0] month_days(input month_t m);
    logic [4:0] d;
    case (m) inside
      MON_FEB:                     d = 5'd28;
      7'd4, 7'd6, 7'd9, 7'd11:     d = 5'd30;
      default:                     d = 5'd31;
    endcase
    return d;
  endfunction

endpackage

FILE: rtl/dsv_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsv_in_if: character channel
// one character beat with its end-of-text mark
// ----------------------------------------------------------------------------
interface dsv_in_if import dsv_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  logic       last;

  modport source (output valid, ch, last, input ready);
  modport sink   (input valid, ch, last, output ready);
endinterface

FILE: rtl/dsv_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsv_out_if: result channel
// one verdict beat with the parsed date
// ----------------------------------------------------------------------------
interface dsv_out_if import dsv_pkg::*; ();
  logic   valid;
  logic   ready;
  logic   valid_res;
  day_t   day;
  month_t month;
  year_t  year;

  modport source (output valid, valid_res, day, month, year, input ready);
  modport sink   (input valid, valid_res, day, month, year, output ready);
endinterface

FILE: rtl/date_string_validator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// date_string_validator: d/m/y date text checker
// parses a date text one character per beat and returns one verdict per text
// ----------------------------------------------------------------------------
//
//  channel   dir  payload                          beat
//  in_chan   in   ch[7:0], last                    one character of the text
//  out_chan  out  valid_res, day, month, year      one verdict per last beat
//
//  one character per cycle sustained; the parse update and the verdict are a
//  single pass of logic between the input register and the result register
//  a last character sits in the input register, then its verdict is registered
//  reset (rst_n low, synchronous) empties both registers and clears the parse
//  a stalled verdict holds back only a last character; others keep flowing
//
module date_string_validator import dsv_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  dsv_in_if.sink    in_chan,
  dsv_out_if.source out_chan
);

  // input register outputs
  logic    in_vld;
  item_t   in_item;

  // parser advance: a last character needs the result slot free
  logic    adv;
  logic    load;

  pstate_t st_nxt;
  res_t    res;

  // result register
  logic    out_vld_r;
  res_t    res_r;

  assign adv  = in_vld && (!in_item.last || !out_vld_r || out_chan.ready);
  assign load = adv && in_item.last;

  dsv_in_stage u_in (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan),
    .adv     (adv),
    .vld     (in_vld),
    .item    (in_item)
  );

  // state after folding in the held character
  dsv_parser u_parse (
    .clk    (clk),
    .rst_n  (rst_n),
    .adv    (adv),
    .item   (in_item),
    .st_nxt (st_nxt)
  );

  // verdict on that state, used only when the character is the last
  dsv_check u_chk (
    .st  (st_nxt),
    .res (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (load) begin
      out_vld_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
    end
  end

  assign out_chan.valid     = out_vld_r;
  assign out_chan.valid_res = res_r.valid_res;
  assign out_chan.day       = res_r.day;
  assign out_chan.month     = res_r.month;
  assign out_chan.year      = res_r.year;

`ifndef SYNTHESIS
  // a good date carries a real day and month
  a_good_ranges: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && res_r.valid_res) |->
      (res_r.day != 7'd0 && res_r.day <= 7'd31 &&
       res_r.month != 7'd0 && res_r.month <= MON_MAX))
    else $error("good verdict with day or month out of range");

  // a rejected text reports all fields as zero
  a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && !res_r.valid_res) |->
      (res_r.day == 7'd0 && res_r.month == 7'd0 && res_r.year == 14'd0))
    else $error("rejected verdict with nonzero fields");

  // february never passes beyond the leap day
  a_feb_limit: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && res_r.valid_res && res_r.month == MON_FEB) |->
      (res_r.day <= {2'b00, DAYS_LEAPFEB}))
    else $error("february day beyond 29");
`endif

endmodule

FILE: rtl/dsv_in_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsv_in_stage: input register
// holds one character beat until the parser takes it
// ----------------------------------------------------------------------------
module dsv_in_stage import dsv_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  dsv_in_if.sink   in_chan,
  input  logic     adv,
  output logic     vld,
  output item_t    item
);

  logic  vld_r;
  item_t item_r;

  assign in_chan.ready = !vld_r || adv;
  assign vld  = vld_r;
  assign item = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (in_chan.valid && in_chan.ready) begin
      vld_r <= 1'b1;
    end else if (adv) begin
      vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_chan.valid && in_chan.ready) begin
      item_r <= '{ch: in_chan.ch, last: in_chan.last};
    end
  end

endmodule

FILE: rtl/dsv_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsv_parser: field tracker and digit accumulators
// folds one character into the parse state, clears it after the last one
// ----------------------------------------------------------------------------
module dsv_parser import dsv_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    adv,
  input  item_t   item,
  output pstate_t st_nxt
);

  pstate_t st_r;
  logic    is_dig;
  logic [3:0] dig;
  logic [2:0] lim;

  assign is_dig = (item.ch >= CH_ZERO) && (item.ch <= CH_NINE);
  assign dig    = 4'(item.ch - CH_ZERO);
  assign lim    = (st_r.field == FLD_DAY || st_r.field == FLD_MONTH) ? DIG_LIM_DM : DIG_LIM_Y;

  always_comb begin
    st_nxt = st_r;
    if (item.ch == CH_SLASH) begin
      if (st_r.slash_cnt < SLASH_SAT) st_nxt.slash_cnt = st_r.slash_cnt + 2'd1;
      if (st_r.field == FLD_DAY || st_r.field == FLD_MONTH) begin
        if (st_r.dig_cnt < 3'd1 || st_r.dig_cnt > DIG_LIM_DM) st_nxt.bad = 1'b1;
        st_nxt.field   = (st_r.field == FLD_DAY) ? FLD_MONTH : FLD_YEAR;
        st_nxt.dig_cnt = 3'd0;
      end else begin
        st_nxt.bad = 1'b1;
      end
    end else if (is_dig) begin
      if (st_r.dig_cnt < lim) begin
        unique case (st_r.field)
          FLD_DAY: begin
            st_nxt.day_acc = (st_r.day_acc << 3) + (st_r.day_acc << 1) + {3'b000, dig};
          end
          FLD_MONTH: begin
            st_nxt.month_acc = (st_r.month_acc << 3) + (st_r.month_acc << 1)
                             + {3'b000, dig};
          end
          default: begin
            st_nxt.year_acc = (st_r.year_acc << 3) + (st_r.year_acc << 1)
                            + {10'd0, dig};
            st_nxt.year_dig = {st_r.year_dig[2:0], dig};
          end
        endcase
      end else begin
        st_nxt.bad = 1'b1;
      end
      if (st_r.dig_cnt < DIG_SAT) st_nxt.dig_cnt = st_r.dig_cnt + 3'd1;
    end else begin
      st_nxt.bad = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '0;
    end else if (adv) begin
      st_r <= item.last ? pstate_t'('0) : st_nxt;
    end
  end

endmodule

FILE: rtl/dsv_check.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsv_check: date verdict
// format, month range and Gregorian day limit on a finished parse state
// ----------------------------------------------------------------------------
module dsv_check import dsv_pkg::*; (
  input  pstate_t st,
  output res_t    res
);

  logic       fmt_ok;
  logic       mon_ok;
  logic       day_ok;
  logic       yr_low;
  logic       cent;
  logic       leap;
  logic [4:0] lo_sum;
  logic [4:0] hi_sum;
  logic [4:0] lim;
  year_t      year_eff;

  assign fmt_ok = !st.bad && (st.slash_cnt == SLASH_NEED) && (st.field == FLD_YEAR)
                && (st.dig_cnt == DIG_LIM_DM || st.dig_cnt == DIG_LIM_Y);
  assign mon_ok = (st.month_acc != 7'd0) && (st.month_acc <= MON_MAX);

  // year mod 4 from the two low digits, mod 400 from the two high digits
  assign yr_low = st.year_acc < YEAR_SMALL;
  assign lo_sum = {st.year_dig[1], 1'b0} + {1'b0, st.year_dig[0]};
  assign hi_sum = {st.year_dig[3], 1'b0} + {1'b0, st.year_dig[2]};
  assign cent   = (st.year_dig[1] == 4'd0) && (st.year_dig[0] == 4'd0);
  // years below 100 sit in the 2000s, whose century is divisible by 400
  assign leap   = (lo_sum[1:0] == 2'd0) && (!cent || yr_low || hi_sum[1:0] == 2'd0);

  assign lim    = (st.month_acc == MON_FEB && leap) ? DAYS_LEAPFEB : month_days(st.month_acc);
  assign day_ok = (st.day_acc != 7'd0) && (st.day_acc <= {2'b00, lim});

  assign year_eff = yr_low ? st.year_acc + YEAR_BASE : st.year_acc;

  always_comb begin
    res = '0;
    if (fmt_ok && mon_ok && day_ok) begin
      res.valid_res = 1'b1;
      res.day       = st.day_acc;
      res.month     = st.month_acc;
      res.year      = year_eff;
    end
  end

endmodule

FILE: test/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the date string validator
// streams d/m/y texts one character per beat with random gaps on both
// channels, predicts every verdict from its own parser copy and compares
// each result beat field by field against the oldest pending verdict
// ----------------------------------------------------------------------------
module tb_top;
  import dsv_pkg::*;

  // idle cycles on either channel before the run is declared stuck
  localparam int IDLE_LIMIT  = 1000;
  // rough size of the random part, in characters
  localparam int CHAR_TARGET = 1800;
  // a verdict trails its last character, so allow a margin at the end
  localparam int TAIL_CYCLES = 8;

  // --------------------------------------------------------------------------
  // verdict predictor and pending-verdict store
  // --------------------------------------------------------------------------
  class date_verdict_model;
    // parser state, mirrors what the block keeps between characters
    field_t     fld;
    logic [1:0] slashes;
    logic [2:0] digits;
    day_t       day_acc;
    month_t     mon_acc;
    year_t      year_acc;
    logic       bad;

    res_t verdicts_due[$];
    int   errors;
    int   n_checked;
    int   n_good_dates;

    function new();
      clear_parse();
      errors       = 0;
      n_checked    = 0;
      n_good_dates = 0;
    endfunction

    function void clear_parse();
      fld      = FLD_DAY;
      slashes  = '0;
      digits   = '0;
      day_acc  = '0;
      mon_acc  = '0;
      year_acc = '0;
      bad      = 1'b0;
    endfunction

    function bit leap_year(int unsigned y);
      return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    endfunction

    // month assumed in 1..12
    function int unsigned month_length(month_t m, int unsigned y);
      case (m)
        MON_FEB:                return leap_year(y) ? DAYS_LEAPFEB : 28;
        7'd4, 7'd6, 7'd9, 7'd11: return 30;
        default:                return 31;
      endcase
    endfunction

    // consume one accepted character, queue a verdict on the last one
    function void note_char(item_t it);
      logic [3:0]  dig;
      logic [2:0]  lim;
      bit          ok;
      int unsigned y;
      res_t        want;
      if (it.ch == CH_SLASH) begin
        if (slashes < SLASH_SAT) slashes++;
        if (fld != FLD_YEAR) begin
          // closing day or month needs 1 or 2 digits
          if (digits < 1 || digits > DIG_LIM_DM) bad = 1'b1;
          fld    = field_t'(fld + 1);
          digits = '0;
        end else begin
          // a third slash
          bad = 1'b1;
        end
      end else if (it.ch >= CH_ZERO && it.ch <= CH_NINE) begin
        dig = 4'(it.ch - CH_ZERO);
        lim = (fld == FLD_YEAR) ? DIG_LIM_Y : DIG_LIM_DM;
        if (digits < lim) begin
          case (fld)
            FLD_DAY:   day_acc  = day_t'(day_acc * 10 + dig);
            FLD_MONTH: mon_acc  = month_t'(mon_acc * 10 + dig);
            default:   year_acc = year_t'(year_acc * 10 + dig);
          endcase
        end else begin
          // digit past the field limit is dropped
          bad = 1'b1;
        end
        if (digits < DIG_SAT) digits++;
      end else begin
        bad = 1'b1;
      end

      if (!it.last) return;

      ok = !bad && slashes == SLASH_NEED && fld == FLD_YEAR &&
           (digits == DIG_LIM_DM || digits == DIG_LIM_Y);
      y = 32'(year_acc);
      if (y < YEAR_SMALL) y += YEAR_BASE;
      if (ok && (mon_acc < 1 || mon_acc > MON_MAX)) ok = 0;
      if (ok && (day_acc < 1 || day_acc > month_length(mon_acc, y))) ok = 0;

      want.valid_res = ok;
      want.day       = ok ? day_acc : '0;
      want.month     = ok ? mon_acc : '0;
      want.year      = ok ? year_t'(y) : '0;
      if (ok) n_good_dates++;
      verdicts_due.push_back(want);
      clear_parse();
    endfunction

    function int pending();
      return verdicts_due.size();
    endfunction

    task report(string what);
      $display("mismatch at %0t: %s", $realtime, what);
      errors++;
    endtask

    task check_verdict(res_t got);
      res_t want;
      n_checked++;
      if (verdicts_due.size() == 0) begin
        report($sformatf("verdict beat with none pending (valid_res %0d)", got.valid_res));
        return;
      end
      want = verdicts_due.pop_front();
      if (got.valid_res !== want.valid_res)
        report($sformatf("valid_res got %0d want %0d", got.valid_res, want.valid_res));
      if (got.day !== want.day)
        report($sformatf("day got %0d want %0d", got.day, want.day));
      if (got.month !== want.month)
        report($sformatf("month got %0d want %0d", got.month, want.month));
      if (got.year !== want.year)
        report($sformatf("year got %0d want %0d", got.year, want.year));
    endtask
  endclass

  // --------------------------------------------------------------------------
  // clock, reset, channels and the block
  // --------------------------------------------------------------------------
  logic clk = 1'b0;
  logic rst_n;

  always #1 clk = ~clk;

  dsv_in_if  in_if ();
  dsv_out_if out_if ();

  date_string_validator DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if)
  );

  date_verdict_model sb = new();

  logic [7:0] text_q[$];   // characters of the text being sent
  int         chars_sent;
  int         texts_sent;
  bit         in_burst;    // sender runs without gaps while set
  bit         out_burst;   // receiver never stalls while set

  // --------------------------------------------------------------------------
  // stimulus helpers
  // --------------------------------------------------------------------------

  // one character beat; valid stays up across back-to-back beats
  task automatic send_char(item_t it);
    int gap;
    gap = in_burst ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.ch    <= it.ch;
    in_if.last  <= it.last;
    do @(posedge clk); while (!in_if.ready);
    sb.note_char(it);
    chars_sent++;
  endtask

  task automatic send_text();
    item_t it;
    foreach (text_q[i]) begin
      it.ch   = text_q[i];
      it.last = (i == text_q.size() - 1);
      send_char(it);
    end
    texts_sent++;
  endtask

  task automatic load_text(string s);
    text_q.delete();
    for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
  endtask

  // hold the sender until every pending verdict has come back
  task automatic drain_verdicts();
    in_if.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // decimal digits of val, zero padded to n places
  task automatic push_number(int unsigned val, int unsigned n);
    int unsigned scale;
    scale = 1;
    repeat (n - 1) scale *= 10;
    repeat (n) begin
      text_q.push_back(8'(CH_ZERO + (val / scale) % 10));
      scale /= 10;
    end
  endtask

  // mostly well-formed dates near the calendar edges, some damaged, some noise
  task automatic make_date_text();
    int unsigned dd, mm, yy, ydig, roll, pos;
    text_q.delete();
    roll = $urandom_range(0, 99);

    // pure noise: random bytes mixed with digits and slashes
    if (roll < 8) begin
      repeat ($urandom_range(1, 8)) begin
        if ($urandom_range(0, 1))
          text_q.push_back(8'($urandom_range(0, 255)));
        else if ($urandom_range(0, 10) == 10)
          text_q.push_back(CH_SLASH);
        else
          text_q.push_back(8'(CH_ZERO + $urandom_range(0, 9)));
      end
      return;
    end

    mm = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 99) : $urandom_range(1, 12);
    case ($urandom_range(0, 3))
      0:       dd = $urandom_range(27, 31);   // month-end boundary
      1:       dd = $urandom_range(0, 99);
      default: dd = $urandom_range(1, 31);
    endcase
    ydig = 4;
    case ($urandom_range(0, 4))
      0: begin
        yy   = $urandom_range(0, 99);
        ydig = 2;
      end
      1:       yy = $urandom_range(0, 99);          // written as 00yy
      2:       yy = $urandom_range(0, 99) * 100;    // century years
      3:       yy = $urandom_range(0, 2499) * 4;    // leap candidates
      default: yy = $urandom_range(0, 9999);
    endcase

    push_number(dd, (dd < 10 && $urandom_range(0, 1)) ? 1 : 2);
    text_q.push_back(CH_SLASH);
    push_number(mm, (mm < 10 && $urandom_range(0, 1)) ? 1 : 2);
    text_q.push_back(CH_SLASH);
    push_number(yy, ydig);

    // damage a fraction of the well-formed texts
    if (roll >= 78) begin
      pos = $urandom_range(0, text_q.size() - 1);
      case ($urandom_range(0, 4))
        0: text_q[pos] = 8'($urandom_range(0, 255));
        1: if (text_q.size() > 1) text_q.delete(pos);
        2: text_q.insert(pos, CH_SLASH);
        3: repeat ($urandom_range(1, 8))
             text_q.insert(pos, 8'(CH_ZERO + $urandom_range(0, 9)));
        default: text_q.insert(pos, 8'($urandom_range(0, 255)));
      endcase
    end
  endtask

  // --------------------------------------------------------------------------
  // main sequence
  // --------------------------------------------------------------------------
  initial begin : stimulus
    rst_n       <= 1'b0;
    in_if.valid <= 1'b0;
    in_if.ch    <= '0;
    in_if.last  <= 1'b0;
    chars_sent  = 0;
    texts_sent  = 0;
    in_burst    = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // directed: leap day of a 400-year, then a four-digit year below 100
    load_text("29/2/00");
    send_text();
    load_text("1/1/0099");
    send_text();
    // too many day digits, then the text ends before the year
    load_text("123/4");
    send_text();
    // empty fields, extra slash, byte extremes
    text_q = '{CH_SLASH, CH_SLASH, CH_SLASH, 8'hFF, 8'h00};
    send_text();
    drain_verdicts();

    // random texts, pausing now and then for all verdicts
    while (chars_sent < CHAR_TARGET) begin
      make_date_text();
      send_text();
      if ($urandom_range(0, 7) == 0) in_burst = !in_burst;
      if (texts_sent % 50 == 0) drain_verdicts();
    end
    drain_verdicts();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("sent %0d texts in %0d character beats, checked %0d verdicts",
             texts_sent, chars_sent, sb.n_checked);
    $display("%0d texts were valid dates, %0d mismatches", sb.n_good_dates, sb.errors);
    if (sb.errors == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

  // --------------------------------------------------------------------------
  // result side: random stalls per beat, check every accepted verdict
  // --------------------------------------------------------------------------
  initial begin : verdict_sink
    int gap;
    out_if.ready <= 1'b0;
    out_burst = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      gap = out_burst ? 0 : $urandom_range(0, 13);
      if (gap > 0) begin
        out_if.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk); while (!(out_if.valid && out_if.ready));
      if ($urandom_range(0, 7) == 0) out_burst = !out_burst;
    end
  end

  always @(posedge clk) begin
    res_t got;
    if (rst_n && out_if.valid && out_if.ready) begin
      got.valid_res = out_if.valid_res;
      got.day       = out_if.day;
      got.month     = out_if.month;
      got.year      = out_if.year;
      sb.check_verdict(got);
    end
  end

  // --------------------------------------------------------------------------
  // watchdog: no beat on either channel for too long ends the run
  // --------------------------------------------------------------------------
  initial begin : watchdog
    int idle;
    idle = 0;
    while (idle < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
        idle = 0;
      else
        idle++;
    end
    $display("stalled for %0d cycles with %0d verdicts pending", IDLE_LIMIT, sb.pending());
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
